### src/ihq_pkg.sv
package ihq_pkg;

  typedef logic signed [15:0] sample_t;
  typedef logic signed [31:0] hist_t;

  // Coefficient magnitudes, exact at 24 fraction bits
  localparam longint C0_24  = 64'sd1129690;
  localparam longint C1_24  = 64'sd12334664;
  localparam longint C2_24  = 64'sd5234785;
  localparam longint C3_24  = 64'sd20661756;
  localparam longint ONE_24 = 64'sd16777216;

  // Round a positive 24-fraction-bit magnitude half up to frac bits
  function automatic longint coef_round(input longint m, input int unsigned frac);
    longint sh;
    sh = 64'(24 - frac);
    return (m + ((longint'(1) << sh) >>> 1)) >>> sh;
  endfunction

  // Q24.8 history value to a 16-bit sample: truncate toward zero, saturate
  function automatic sample_t out16(input hist_t y);
    logic signed [23:0] t;
    t = y[31:8] + {23'b0, y[31] & (|y[7:0])};
    if ((&t[23:15]) || (~|t[23:15])) begin
      return t[15:0];
    end else if (t[23]) begin
      return 16'sh8000;
    end else begin
      return 16'sh7fff;
    end
  endfunction

endpackage

### src/ihq_tap_cell.sv
module ihq_tap_cell #(
  parameter int unsigned CW = 18,
  parameter logic signed [CW-1:0] COEF = '0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  ihq_pkg::sample_t      sample_i,
  output ihq_pkg::sample_t      sample_o,
  output logic signed [15+CW:0] prod_o
);
  import ihq_pkg::*;

  sample_t                sample_q;
  logic signed [15+CW:0]  prod_q, prod_d;

  assign prod_d = COEF * sample_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
      prod_q   <= '0;
    end else if (en_i) begin
      sample_q <= sample_i;
      prod_q   <= prod_d;
    end
  end

  assign sample_o = sample_q;
  assign prod_o   = prod_q;

endmodule

### src/ihq_fb_sect.sv
module ihq_fb_sect #(
  parameter int unsigned FRAC = 16,
  parameter int unsigned CW = 18,
  parameter int unsigned FW = 36,
  parameter logic signed [CW-1:0] COEF_A = '0,
  parameter logic signed [CW-1:0] COEF_B = '0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic signed [FW-1:0] ff_i,
  output ihq_pkg::hist_t       y_o
);
  import ihq_pkg::*;

  localparam int unsigned AW = FRAC + 36;
  localparam int unsigned QW = AW - FRAC;
  localparam int unsigned PW = 32 + CW;

  hist_t                y0_q, y1_q, y2_q, y_d;
  logic signed [PW-1:0] pa_q, pb_q, pa_d, pb_d;
  logic signed [AW-1:0] acc;
  logic        [QW-1:0] quo;
  logic                 rnd;

  // pa holds COEF_A * y[n-2], pb holds COEF_B * y[n-4] for the item now here
  assign acc = (AW'(ff_i) <<< 8) + AW'(pa_q) - AW'(pb_q);
  assign rnd = acc[AW-1] & (|acc[FRAC-1:0]);
  assign quo = acc[AW-1:FRAC] + {{(QW-1){1'b0}}, rnd};

  always_comb begin
    if ((&quo[QW-1:31]) || (~|quo[QW-1:31])) begin
      y_d = quo[31:0];
    end else if (quo[QW-1]) begin
      y_d = 32'sh8000_0000;
    end else begin
      y_d = 32'sh7fff_ffff;
    end
  end

  assign pa_d = COEF_A * y0_q;
  assign pb_d = COEF_B * y2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y0_q <= '0;
      y1_q <= '0;
      y2_q <= '0;
      pa_q <= '0;
      pb_q <= '0;
    end else if (en_i) begin
      y0_q <= y_d;
      y1_q <= y0_q;
      y2_q <= y1_q;
      pa_q <= pa_d;
      pb_q <= pb_d;
    end
  end

  assign y_o = y0_q;

endmodule

### src/iir_hilbert_quadrature_pair_top.sv
// Splits a signed 16-bit sample stream into in-phase and quadrature streams with a
// 4th-order and a 5th-order allpass IIR filter. Each input beat gives exactly one
// output beat via the tap cells, feedforward registers, filter history and output
// register in turn. One beat is taken per cycle unless the output stalls: the
// feedforward taps run through a chain of six multiply cells and the nearest
// recursion term lies two samples back, so each recursive product is formed one
// sample ahead and only the closing add lies before the history register. Both
// sides stall together: s_axis_tready_o follows m_axis_tready_i while an output
// beat is waiting. Coefficients carry COEF_FRAC_BITS fraction bits (12 to 24);
// filter history is in Q24.8, outputs truncate toward zero and saturate to 16 bits.
module iir_hilbert_quadrature_pair_top #(
  parameter int unsigned COEF_FRAC_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  ihq_pkg::sample_t s_axis_tdata_i,   // [15:0] sample
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o    // [15:0] i_out, [31:16] q_out
);
  import ihq_pkg::*;

  localparam int unsigned CW = COEF_FRAC_BITS + 2;
  localparam int unsigned PW = 16 + CW;
  localparam int unsigned FW = PW + 2;
  localparam int unsigned NTAP = 6;

  localparam logic signed [CW-1:0] K_C0   = CW'(coef_round(C0_24, COEF_FRAC_BITS));
  localparam logic signed [CW-1:0] K_C1   = CW'(coef_round(C1_24, COEF_FRAC_BITS));
  localparam logic signed [CW-1:0] K_C2   = CW'(coef_round(C2_24, COEF_FRAC_BITS));
  localparam logic signed [CW-1:0] K_C3   = CW'(coef_round(C3_24, COEF_FRAC_BITS));
  localparam logic signed [CW-1:0] K_NC1  = CW'(-coef_round(C1_24, COEF_FRAC_BITS));
  localparam logic signed [CW-1:0] K_NC3  = CW'(-coef_round(C3_24, COEF_FRAC_BITS));
  localparam logic signed [CW-1:0] K_ONE  = CW'(coef_round(ONE_24, COEF_FRAC_BITS));

  // Tap k weights x[n-k]; even taps feed the in-phase path, odd taps the quadrature
  localparam logic signed [CW-1:0] TAP_COEF [NTAP] = '{K_C0, K_C2, K_NC1, K_NC3, K_ONE, K_ONE};

  logic                 en;
  logic                 acc_in;
  logic                 v1_q, v2_q, v3_q, out_valid_q;
  sample_t              chain [NTAP];
  logic signed [PW-1:0] tap_prod [NTAP];
  logic signed [FW-1:0] ffi_q, ffq_q, ffi_d, ffq_d;
  hist_t                yi, yq;
  logic [31:0]          tdata_q;

  // Valid flags advance together on en; bubbles drain while the output is free
  assign en              = !out_valid_q || m_axis_tready_i;
  assign acc_in          = s_axis_tvalid_i && en;
  assign s_axis_tready_o = en;

  assign chain[0] = s_axis_tdata_i;

  for (genvar k = 0; k < NTAP; k++) begin : g_tap
    if (k < NTAP - 1) begin : g_mid
      ihq_tap_cell #(
        .CW   (CW),
        .COEF (TAP_COEF[k])
      ) u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .en_i     (acc_in),
        .sample_i (chain[k]),
        .sample_o (chain[k+1]),
        .prod_o   (tap_prod[k])
      );
    end else begin : g_end
      ihq_tap_cell #(
        .CW   (CW),
        .COEF (TAP_COEF[k])
      ) u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .en_i     (acc_in),
        .sample_i (chain[k]),
        .sample_o (),
        .prod_o   (tap_prod[k])
      );
    end
  end

  assign ffi_d = FW'(tap_prod[0]) + FW'(tap_prod[2]) + FW'(tap_prod[4]);
  assign ffq_d = FW'(tap_prod[1]) + FW'(tap_prod[3]) + FW'(tap_prod[5]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= s_axis_tvalid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && v1_q) begin
      ffi_q <= ffi_d;
      ffq_q <= ffq_d;
    end
    if (en && v3_q) begin
      tdata_q <= {out16(yq), out16(yi)};
    end
  end

  ihq_fb_sect #(
    .FRAC   (COEF_FRAC_BITS),
    .CW     (CW),
    .FW     (FW),
    .COEF_A (K_C1),
    .COEF_B (K_C0)
  ) u_fb_i (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en && v2_q),
    .ff_i   (ffi_q),
    .y_o    (yi)
  );

  ihq_fb_sect #(
    .FRAC   (COEF_FRAC_BITS),
    .CW     (CW),
    .FW     (FW),
    .COEF_A (K_C3),
    .COEF_B (K_C2)
  ) u_fb_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en && v2_q),
    .ff_i   (ffq_q),
    .y_o    (yq)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = tdata_q;

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> v1_q)
    else $error("accepted beat did not enter the tap stage");

  a_result_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && en) |=> m_axis_tvalid_o)
    else $error("finished result did not reach the output register");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(v1_q) && $stable(v2_q) && $stable(v3_q)))
    else $error("pipeline moved during a stall");

  a_bubble_keeps_hist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(en && v2_q) |=> ($stable(yi) && $stable(yq)))
    else $error("filter history changed without a beat");

endmodule
